// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
// depends on a clock named clk and an active-low reset named rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication into the next cycle, no reset masking
`define ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) else $error("lbl failed");
// implication into the next cycle, masked during reset
`define ASSERT_NEXT_RST(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("lbl failed");
// same-cycle implication, masked during reset
`define ASSERT_NOW_RST(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("lbl failed");
`endif

// ----- rtl/perj_pkg.sv -----
// types, constants and helper functions of the pose edge residual block
// no dependencies
package perj_pkg;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int CORDIC_STEPS   = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic               flip;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic [31:0]        z;
  } perj_rot_t;

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] obs_dx;
    logic signed [31:0] obs_dy;
    logic [15:0]        tw;
    logic signed [31:0] hres;
  } perj_carry_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

// ----- rtl/perj_if.sv -----
// item channels of the pose edge residual block
// depends on nothing
interface perj_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [15:0] start_heading;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [15:0] end_heading;
  logic signed [31:0] observed_dx;
  logic signed [31:0] observed_dy;
  logic signed [15:0] observed_dheading;
  logic [15:0]        trans_wt;
  logic [15:0]        rot_wt;
  modport source(output valid, start_x, start_y, start_heading, end_x, end_y,
                 end_heading, observed_dx, observed_dy, observed_dheading,
                 trans_wt, rot_wt, input ready);
  modport sink(input valid, start_x, start_y, start_heading, end_x, end_y,
               end_heading, observed_dx, observed_dy, observed_dheading,
               trans_wt, rot_wt, output ready);
endinterface

interface perj_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] residual_x;
  logic signed [31:0] residual_y;
  logic signed [31:0] residual_heading;
  logic signed [31:0] weighted_cosine;
  logic signed [31:0] weighted_sine;
  logic signed [31:0] dres_x_dheading;
  logic signed [31:0] dres_y_dheading;
  modport source(output valid, residual_x, residual_y, residual_heading,
                 weighted_cosine, weighted_sine, dres_x_dheading, dres_y_dheading,
                 input ready);
  modport sink(input valid, residual_x, residual_y, residual_heading,
               weighted_cosine, weighted_sine, dres_x_dheading, dres_y_dheading,
               output ready);
endinterface

// ----- rtl/perj_cordic_cell.sv -----
// one cordic rotation cell, passes the edge payload to the next cell
// depends on perj_pkg
module perj_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  perj_pkg::perj_rot_t   in_rot,
  input  perj_pkg::perj_carry_t in_carry,
  output logic                 out_valid_r,
  output perj_pkg::perj_rot_t   out_rot_r,
  output perj_pkg::perj_carry_t out_carry_r
);
  import perj_pkg::*;

  logic signed [33:0] xs, ys;
  perj_rot_t rot_nxt;

  always_comb begin
    xs = in_rot.x >>> STEP;
    ys = in_rot.y >>> STEP;
    rot_nxt.flip = in_rot.flip;
    if (in_rot.z[31]) begin
      rot_nxt.x = in_rot.x + ys;
      rot_nxt.y = in_rot.y - xs;
      rot_nxt.z = in_rot.z + atan_turn(STEP);
    end else begin
      rot_nxt.x = in_rot.x - ys;
      rot_nxt.y = in_rot.y + xs;
      rot_nxt.z = in_rot.z - atan_turn(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rot_r   <= rot_nxt;
      out_carry_r <= in_carry;
    end
  end
endmodule

// ----- rtl/perj_post.sv -----
// rounding, weighting and jacobian stages after the cordic chain
// depends on perj_pkg
module perj_post (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  perj_pkg::perj_rot_t   in_rot,
  input  perj_pkg::perj_carry_t in_carry,
  output logic                 out_valid_r,
  output logic signed [31:0]   res_x_r,
  output logic signed [31:0]   res_y_r,
  output logic signed [31:0]   res_h_r,
  output logic signed [31:0]   wcos_r,
  output logic signed [31:0]   wsin_r,
  output logic signed [31:0]   dres_x_r,
  output logic signed [31:0]   dres_y_r
);
  import perj_pkg::*;

  logic [3:0] v_r;
  perj_carry_t c1_r, c2_r, c3_r, c4_r;

  // stage 1: unfold, round, clamp
  logic signed [34:0] xf, yf, xr, yr;
  logic signed [17:0] cos_nxt, sin_nxt, cos_r, sin_r;

  function automatic logic signed [17:0] clamp_unit(input logic signed [34:0] v);
    logic signed [17:0] r;
    if (v > 35'sd65536) r = 18'sd65536;
    else if (v < -35'sd65536) r = -18'sd65536;
    else r = v[17:0];
    return r;
  endfunction

  always_comb begin
    xf = in_rot.flip ? -35'(in_rot.x) : 35'(in_rot.x);
    yf = in_rot.flip ? -35'(in_rot.y) : 35'(in_rot.y);
    xr = (xf + 35'sd8192) >>> 14;
    yr = (yf + 35'sd8192) >>> 14;
    cos_nxt = clamp_unit(xr);
    sin_nxt = clamp_unit(yr);
  end

  // stage 2: rotation and weight products
  logic signed [50:0] cdx_r, sdy_r, cdy_r, sdx_r;
  logic signed [34:0] twc_r, tws_r;

  // stage 3: rounding
  logic signed [51:0] rxs, rys, rxw, ryw;
  logic signed [34:0] wcw, wsw;
  logic signed [35:0] rx_r, ry_r;
  logic signed [26:0] wc3_r, ws3_r;

  always_comb begin
    rxs = 52'(cdx_r) + 52'(sdy_r);
    rys = 52'(cdy_r) - 52'(sdx_r);
    rxw = (rxs + 52'sd32768) >>> 16;
    ryw = (rys + 52'sd32768) >>> 16;
    wcw = (twc_r + 35'sd128) >>> 8;
    wsw = (tws_r + 35'sd128) >>> 8;
  end

  // stage 4: residual and heading derivative products
  logic signed [36:0] ex, ey;
  logic signed [53:0] tex_r, tey_r;
  logic signed [59:0] wsdx_r, wcdy_r, wcdx_r, wsdy_r;
  logic signed [26:0] wc4_r, ws4_r;

  always_comb begin
    ex = 37'(c3_r.obs_dx) - 37'(rx_r);
    ey = 37'(c3_r.obs_dy) - 37'(ry_r);
  end

  // stage 5: final rounding and saturation
  logic signed [53:0] txr, tyr;
  logic signed [60:0] dxs, dys, dxr, dyr;

  always_comb begin
    txr = (tex_r + 54'sd128) >>> 8;
    tyr = (tey_r + 54'sd128) >>> 8;
    dxs = 61'(wsdx_r) - 61'(wcdy_r);
    dys = 61'(wcdx_r) + 61'(wsdy_r);
    dxr = (dxs + 61'sd32768) >>> 16;
    dyr = (dys + 61'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[2:0], in_valid};
      out_valid_r <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r  <= cos_nxt;
      sin_r  <= sin_nxt;
      c1_r   <= in_carry;

      cdx_r  <= cos_r * c1_r.dx;
      sdy_r  <= sin_r * c1_r.dy;
      cdy_r  <= cos_r * c1_r.dy;
      sdx_r  <= sin_r * c1_r.dx;
      twc_r  <= $signed({1'b0, c1_r.tw}) * cos_r;
      tws_r  <= $signed({1'b0, c1_r.tw}) * sin_r;
      c2_r   <= c1_r;

      rx_r   <= rxw[35:0];
      ry_r   <= ryw[35:0];
      wc3_r  <= wcw[26:0];
      ws3_r  <= wsw[26:0];
      c3_r   <= c2_r;

      tex_r  <= $signed({1'b0, c3_r.tw}) * ex;
      tey_r  <= $signed({1'b0, c3_r.tw}) * ey;
      wsdx_r <= ws3_r * c3_r.dx;
      wcdy_r <= wc3_r * c3_r.dy;
      wcdx_r <= wc3_r * c3_r.dx;
      wsdy_r <= ws3_r * c3_r.dy;
      wc4_r  <= wc3_r;
      ws4_r  <= ws3_r;
      c4_r   <= c3_r;

      res_x_r  <= sat32(64'(txr));
      res_y_r  <= sat32(64'(tyr));
      res_h_r  <= c4_r.hres;
      wcos_r   <= sat32(64'(wc4_r));
      wsin_r   <= sat32(64'(ws4_r));
      dres_x_r <= sat32(64'(dxr));
      dres_y_r <= sat32(64'(dyr));
    end
  end
endmodule

// ----- rtl/pose_edge_residual_jacobian_2d.sv -----
// pipeline: 1 input stage, 24 cordic cells, 5 arithmetic stages
// throughput: one item per cycle while the pipeline is not stalled
// the whole pipeline advances when the output register is empty or taken
// reset: synchronous active-low rst_n clears all stage valid bits
// top level of the pose edge residual and jacobian block
// depends on perj_pkg, perj_if, perj_cordic_cell, perj_post
`include "assert_macros.svh"
module pose_edge_residual_jacobian_2d #(
  parameter int ANGLE_BITS = perj_pkg::ANGLE_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  perj_in_if.sink    in_edge,
  perj_out_if.source out_res
);
  import perj_pkg::*;

  logic en;
  assign en = !out_res.valid || out_res.ready;
  assign in_edge.ready = en;

  logic [ANGLE_BITS-1:0] sh, eh, oh, dh;
  logic [31:0]           z_raw, z_q1;
  logic                  flip;
  logic signed [ANGLE_BITS+16:0] hprod;
  perj_rot_t   rot0_nxt;
  perj_carry_t car0_nxt;

  always_comb begin
    sh    = ANGLE_BITS'($signed(in_edge.start_heading));
    eh    = ANGLE_BITS'($signed(in_edge.end_heading));
    oh    = ANGLE_BITS'($signed(in_edge.observed_dheading));
    dh    = oh - eh + sh;
    z_raw = {sh, {(32-ANGLE_BITS){1'b0}}};
    z_q1  = z_raw + 32'h40000000;
    flip  = z_q1[31];
    rot0_nxt.flip = flip;
    rot0_nxt.x    = CORDIC_GAIN;
    rot0_nxt.y    = '0;
    rot0_nxt.z    = flip ? z_raw + 32'h80000000 : z_raw;
    hprod = $signed({1'b0, in_edge.rot_wt}) * $signed(dh);
    car0_nxt.dx     = 33'(in_edge.end_x) - 33'(in_edge.start_x);
    car0_nxt.dy     = 33'(in_edge.end_y) - 33'(in_edge.start_y);
    car0_nxt.obs_dx = in_edge.observed_dx;
    car0_nxt.obs_dy = in_edge.observed_dy;
    car0_nxt.tw     = in_edge.trans_wt;
    car0_nxt.hres   = sat32(64'(hprod));
  end

  logic        vq   [CORDIC_STEPS+1];
  perj_rot_t   rotq [CORDIC_STEPS+1];
  perj_carry_t carq [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq[0] <= 1'b0;
    end else if (en) begin
      vq[0] <= in_edge.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rotq[0] <= rot0_nxt;
      carq[0] <= car0_nxt;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    perj_cordic_cell #(.STEP(g)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .in_valid   (vq[g]),
      .in_rot     (rotq[g]),
      .in_carry   (carq[g]),
      .out_valid_r(vq[g+1]),
      .out_rot_r  (rotq[g+1]),
      .out_carry_r(carq[g+1])
    );
  end

  perj_post u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (vq[CORDIC_STEPS]),
    .in_rot     (rotq[CORDIC_STEPS]),
    .in_carry   (carq[CORDIC_STEPS]),
    .out_valid_r(out_res.valid),
    .res_x_r    (out_res.residual_x),
    .res_y_r    (out_res.residual_y),
    .res_h_r    (out_res.residual_heading),
    .wcos_r     (out_res.weighted_cosine),
    .wsin_r     (out_res.weighted_sine),
    .dres_x_r   (out_res.dres_x_dheading),
    .dres_y_r   (out_res.dres_y_dheading)
  );

  `ASSERT_NEXT(a_reset_clears_out, !rst_n, !out_res.valid)
  `ASSERT_NEXT_RST(a_accept_enters, in_edge.valid && in_edge.ready, vq[0])
  `ASSERT_NEXT_RST(a_stall_holds_chain, !en && vq[CORDIC_STEPS], vq[CORDIC_STEPS])
  `ASSERT_NOW_RST(a_ready_when_free, !out_res.valid, in_edge.ready)
endmodule
